// ----- design/htqp_pkg.sv -----
`timescale 1ns / 1ps

package htqp_pkg;

  localparam int unsigned KEY_W = 31;
  localparam int unsigned IDX_W = 4;

  // two-entry queue between front and back
  localparam int unsigned FIFO_DEPTH = 2;

  localparam logic REQ_INSERT = 1'b0;
  localparam logic REQ_SEARCH = 1'b1;

  typedef enum logic [1:0] {
    ST_INSERTED = 2'd0,
    ST_FULL     = 2'd1,
    ST_FOUND    = 2'd2,
    ST_MISSING  = 2'd3
  } status_e;

  typedef struct packed {
    logic             req_type;
    logic [KEY_W-1:0] key;
  } req_t;

  typedef struct packed {
    status_e          status;
    logic [IDX_W-1:0] slot_index;
  } rsp_t;

endpackage

// ----- design/htqp_fifo.sv -----
`timescale 1ns / 1ps

module htqp_fifo #(
  parameter int unsigned DataW = 8
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  logic [DataW-1:0] data_i,
  output logic             full_o,
  input  logic             pop_i,
  output logic [DataW-1:0] data_o,
  output logic             empty_o
);
  import htqp_pkg::*;

  localparam int unsigned PtrW = $clog2(FIFO_DEPTH);
  localparam int unsigned CntW = $clog2(FIFO_DEPTH + 1);

  logic [DataW-1:0] mem_q [FIFO_DEPTH];
  logic [PtrW-1:0]  wr_ptr_q, rd_ptr_q;
  logic [CntW-1:0]  cnt_q;
  logic             do_push, do_pop;

  assign full_o  = (cnt_q == CntW'(FIFO_DEPTH));
  assign empty_o = (cnt_q == '0);
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign data_o  = mem_q[rd_ptr_q];

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_q <= (wr_ptr_q == PtrW'(FIFO_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_q <= (rd_ptr_q == PtrW'(FIFO_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
      end
      if (do_push && !do_pop) begin
        cnt_q <= cnt_q + 1'b1;
      end else if (do_pop && !do_push) begin
        cnt_q <= cnt_q - 1'b1;
      end
    end
  end

endmodule

// ----- design/htqp_front.sv -----
`timescale 1ns / 1ps

module htqp_front #(
  parameter int unsigned TableSize = 11,
  parameter int unsigned SlotW     = 4,
  parameter int unsigned JobW      = 2 + 31 + SlotW
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 start,
  output logic                 busy,
  input  htqp_pkg::req_t       req_i,
  output logic                 push_o,
  output logic [JobW-1:0]      job_o,
  input  logic                 full_i
);
  import htqp_pkg::*;

  typedef enum logic [3:0] {
    F_IDLE = 4'b0001,
    F_MUL  = 4'b0010,
    F_RED  = 4'b0100,
    F_PUSH = 4'b1000
  } front_state_e;

  // floor(2^Shift / size) fits 32 bits and keeps the quotient estimate
  // at most one below the true quotient for any 31-bit key
  localparam int unsigned    Shift     = KEY_W + SlotW;
  localparam int unsigned    ProdW     = KEY_W + 32;
  localparam logic [63:0]    RecipWide = (64'd1 << Shift) / 64'(TableSize);
  localparam logic [31:0]    Recip     = RecipWide[31:0];
  localparam logic [SlotW:0] ModN      = (SlotW + 1)'(TableSize);

  front_state_e     state_q, state_d;
  logic             search_q;
  logic [KEY_W-1:0] key_q;
  logic [ProdW-1:0] prod_q;
  logic [SlotW-1:0] rem_q, rem_d;
  logic [SlotW:0]   q_lo, qd_lo, r_est;
  logic             accept;

  assign busy   = (state_q != F_IDLE);
  assign accept = start && !busy;

  // key mod size from the quotient estimate; only the low bits matter
  // since the raw remainder is below twice the size
  always_comb begin
    q_lo  = prod_q[Shift +: SlotW + 1];
    qd_lo = q_lo * ModN;
    r_est = key_q[SlotW:0] - qd_lo;
    rem_d = (r_est >= ModN) ? SlotW'(r_est - ModN) : r_est[SlotW-1:0];
  end

  always_comb begin
    state_d = state_q;
    push_o  = 1'b0;
    case (state_q)
      F_IDLE: begin
        if (accept) state_d = F_MUL;
      end
      F_MUL: begin
        state_d = F_RED;
      end
      F_RED: begin
        state_d = F_PUSH;
      end
      F_PUSH: begin
        if (!full_i) begin
          push_o  = 1'b1;
          state_d = F_IDLE;
        end
      end
      default: state_d = F_IDLE;
    endcase
  end

  assign job_o = {search_q, (key_q == '0), key_q, rem_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= F_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      search_q <= (req_i.req_type == REQ_SEARCH);
      key_q    <= req_i.key;
    end
    if (state_q == F_MUL) begin
      prod_q <= ProdW'(key_q) * ProdW'(Recip);
    end
    if (state_q == F_RED) begin
      rem_q <= rem_d;
    end
  end

endmodule

// ----- design/htqp_back.sv -----
`timescale 1ns / 1ps

module htqp_back #(
  parameter int unsigned TableSize = 11,
  parameter int unsigned SlotW     = 4,
  parameter int unsigned JobW      = 2 + 31 + SlotW
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            empty_i,
  input  logic [JobW-1:0] job_i,
  output logic            pop_o,
  output logic            done_o,
  output htqp_pkg::rsp_t  rsp_o
);
  import htqp_pkg::*;

  typedef enum logic [1:0] {
    B_IDLE = 2'b01,
    B_RUN  = 2'b10
  } back_state_e;

  localparam int unsigned CntW = $clog2(TableSize + 1);
  localparam logic [SlotW:0] ModN = (SlotW + 1)'(TableSize);

  back_state_e      state_q, state_d;
  logic             search_q;
  logic [KEY_W-1:0] key_q;
  logic [SlotW-1:0] slot_q, inc_q;
  logic [CntW-1:0]  iss_cnt_q;
  logic             chk_q, chk_last_q;
  logic [SlotW-1:0] chk_slot_q;
  logic [KEY_W-1:0] rd_data_q;
  logic             rd_vld_q;
  logic [TableSize-1:0] vld_q;
  logic [KEY_W-1:0] mem_q [TableSize];

  logic             job_search, job_zero;
  logic [KEY_W-1:0] job_key;
  logic [SlotW-1:0] job_home;
  logic             issue, finish, wr_en;
  logic [SlotW:0]   slot_sum, inc_sum;
  logic [SlotW-1:0] slot_nx, inc_nx;
  logic             done_d;
  rsp_t             rsp_d;
  logic [SlotW+IDX_W-1:0] idx_ext;

  assign job_search = job_i[JobW-1];
  assign job_zero   = job_i[JobW-2];
  assign job_key    = job_i[SlotW+KEY_W-1:SlotW];
  assign job_home   = job_i[SlotW-1:0];

  assign pop_o = (state_q == B_IDLE) && !empty_i;
  assign issue = (state_q == B_RUN) && (iss_cnt_q != CntW'(TableSize));

  // next probe: slot += 2i+1, increment += 2, both mod size
  always_comb begin
    slot_sum = {1'b0, slot_q} + {1'b0, inc_q};
    slot_nx  = (slot_sum >= ModN) ? SlotW'(slot_sum - ModN) : slot_sum[SlotW-1:0];
    inc_sum  = {1'b0, inc_q} + (SlotW + 1)'(2);
    inc_nx   = (inc_sum >= ModN) ? SlotW'(inc_sum - ModN) : inc_sum[SlotW-1:0];
  end

  assign idx_ext = {{IDX_W{1'b0}}, chk_slot_q};

  always_comb begin
    state_d = state_q;
    finish  = 1'b0;
    wr_en   = 1'b0;
    done_d  = 1'b0;
    rsp_d.status     = ST_MISSING;
    rsp_d.slot_index = '0;
    case (state_q)
      B_IDLE: begin
        if (!empty_i) begin
          if (job_zero) begin
            done_d       = 1'b1;
            rsp_d.status = job_search ? ST_MISSING : ST_FULL;
          end else begin
            state_d = B_RUN;
          end
        end
      end
      B_RUN: begin
        if (chk_q) begin
          if (search_q) begin
            if (rd_vld_q && (rd_data_q == key_q)) begin
              finish           = 1'b1;
              rsp_d.status     = ST_FOUND;
              rsp_d.slot_index = idx_ext[IDX_W-1:0];
            end else if (!rd_vld_q) begin
              finish       = 1'b1;
              rsp_d.status = ST_MISSING;
            end else if (chk_last_q) begin
              finish       = 1'b1;
              rsp_d.status = ST_MISSING;
            end
          end else begin
            if (!rd_vld_q) begin
              finish           = 1'b1;
              wr_en            = 1'b1;
              rsp_d.status     = ST_INSERTED;
              rsp_d.slot_index = idx_ext[IDX_W-1:0];
            end else if (chk_last_q) begin
              finish       = 1'b1;
              rsp_d.status = ST_FULL;
            end
          end
        end
        if (finish) begin
          done_d  = 1'b1;
          state_d = B_IDLE;
        end
      end
      default: state_d = B_IDLE;
    endcase
  end

  // slot storage: read data registered, one probe a cycle
  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem_q[chk_slot_q] <= key_q;
    end
    if (issue) begin
      rd_data_q <= mem_q[slot_q];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= B_IDLE;
      vld_q      <= '0;
      rd_vld_q   <= 1'b0;
      chk_q      <= 1'b0;
      chk_last_q <= 1'b0;
      iss_cnt_q  <= '0;
      done_o     <= 1'b0;
    end else begin
      state_q <= state_d;
      done_o  <= done_d;
      if (wr_en) begin
        vld_q[chk_slot_q] <= 1'b1;
      end
      if (issue) begin
        rd_vld_q <= vld_q[slot_q];
      end
      chk_q      <= issue && !finish;
      chk_last_q <= (iss_cnt_q == CntW'(TableSize - 1));
      if (pop_o) begin
        iss_cnt_q <= '0;
      end else if (issue) begin
        iss_cnt_q <= iss_cnt_q + 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (done_d) begin
      rsp_o <= rsp_d;
    end
    if (issue) begin
      chk_slot_q <= slot_q;
      slot_q     <= slot_nx;
      inc_q      <= inc_nx;
    end
    if (pop_o) begin
      search_q <= job_search;
      key_q    <= job_key;
      slot_q   <= job_home;
      inc_q    <= SlotW'(1);
    end
  end

endmodule

// ----- design/hash_table_quadratic_probe.sv -----
`timescale 1ns / 1ps

// channel   | direction | handshake              | payload
// ----------+-----------+------------------------+------------------------------
// request   | in        | start high, busy low   | req_i  (req_type, key)
// result    | out       | done_o for one cycle   | rsp_o  (status, slot_index)
//
// a request beat is hashed in the front (key times a reciprocal of the size in F_MUL, then
// one correction step in F_RED) and queued in F_PUSH, which waits there while the queue is
// full; the front then takes the next beat
// the back probes one slot a cycle through the registered read port of the slot
// memory, up to TABLE_SIZE probes for each request beat
// reset clears the slot valid bits at once; no clearing pass is needed
// the receiver cannot stall: every result beat is shown for exactly one cycle
module hash_table_quadratic_probe #(
  parameter int unsigned TABLE_SIZE = 11
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           start,
  output logic           busy,
  input  htqp_pkg::req_t req_i,
  output logic           done_o,
  output htqp_pkg::rsp_t rsp_o
);
  import htqp_pkg::*;

  // slot number width; also the width of the hashed home slot
  localparam int unsigned SlotW = $clog2(TABLE_SIZE);
  // queued job: search flag, zero-key flag, key, home slot
  localparam int unsigned JobW  = 2 + KEY_W + SlotW;

  logic            push, pop, q_full, q_empty;
  logic [JobW-1:0] job_in, job_out;

  // front: takes request beats and hashes the key to its home slot
  htqp_front #(
    .TableSize (TABLE_SIZE),
    .SlotW     (SlotW),
    .JobW      (JobW)
  ) u_front (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start  (start),
    .busy   (busy),
    .req_i  (req_i),
    .push_o (push),
    .job_o  (job_in),
    .full_i (q_full)
  );

  // short queue so hashing of the next key overlaps the probe walk
  htqp_fifo #(
    .DataW (JobW)
  ) u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .data_i  (job_in),
    .full_o  (q_full),
    .pop_i   (pop),
    .data_o  (job_out),
    .empty_o (q_empty)
  );

  // back: quadratic probe walk over the slot memory, writes on insert
  htqp_back #(
    .TableSize (TABLE_SIZE),
    .SlotW     (SlotW),
    .JobW      (JobW)
  ) u_back (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .empty_i (q_empty),
    .job_i   (job_out),
    .pop_o   (pop),
    .done_o  (done_o),
    .rsp_o   (rsp_o)
  );

endmodule

// ----- dv/hash_table_quadratic_probe_tb.sv -----
`timescale 1ns / 1ps

// hash table with quadratic probing, checked against a mirror of the slot store
// request beats go in through start/busy, result beats come back on done_o
module hash_table_quadratic_probe_tb;

  import htqp_pkg::*;

  localparam int unsigned SLOTS       = 11;
  localparam int unsigned RAND_ITEMS  = 1430;
  localparam int unsigned TAIL_ITEMS  = 150;   // last beats go out back to back
  localparam int unsigned SETTLE      = 40;    // wait for stray result beats after the drain, with margin
  localparam int unsigned DRAIN_LIMIT = 5000;
  localparam int unsigned MAX_PRINTS  = 40;

  logic clk_i  = 1'b0;
  logic rst_ni = 1'b0;
  logic start  = 1'b0;
  req_t req_i  = '0;
  logic busy;
  logic done_o;
  rsp_t rsp_o;

  hash_table_quadratic_probe #(
    .TABLE_SIZE(SLOTS)
  ) u_top (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .start (start),
    .busy  (busy),
    .req_i (req_i),
    .done_o(done_o),
    .rsp_o (rsp_o)
  );

  // mirror of the slot store, zero means empty
  logic [KEY_W-1:0] slot_mirror [SLOTS];

  req_t        req_backlog [$];   // request beats still to be sent
  rsp_t        rsp_pending [$];   // predicted result beats, oldest first
  int unsigned gap_left   = 0;
  int unsigned err_count  = 0;
  int unsigned n_sent     = 0;
  int unsigned n_checked  = 0;
  int unsigned n_status [4];

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  initial begin
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
  end

  initial begin
    #5_000_000;
    $display("timeout: %0d results still awaited", rsp_pending.size());
    $display("[FAIL] regression broken");
    $finish;
  end

  task automatic flag_mismatch(input string what);
    err_count++;
    if (err_count <= MAX_PRINTS) $display("%0t mismatch: %s", $realtime, what);
  endtask

  // walk the quadratic probe chain from the home slot and update the mirror
  function automatic rsp_t predict_lookup(input req_t rq);
    rsp_t        r;
    int unsigned home;
    int unsigned pos;
    r.status     = (rq.req_type == REQ_SEARCH) ? ST_MISSING : ST_FULL;
    r.slot_index = '0;
    // zero key is reserved for empty slots: refused or not found
    if (rq.key == '0) return r;
    home = rq.key % SLOTS;
    for (int unsigned i = 0; i < SLOTS; i++) begin
      pos = (home + i * i) % SLOTS;
      if (rq.req_type == REQ_SEARCH) begin
        if (slot_mirror[pos] == rq.key) begin
          r.status     = ST_FOUND;
          r.slot_index = pos[IDX_W-1:0];
          return r;
        end
        if (slot_mirror[pos] == '0) return r;
      end else if (slot_mirror[pos] == '0) begin
        slot_mirror[pos] = rq.key;
        r.status         = ST_INSERTED;
        r.slot_index     = pos[IDX_W-1:0];
        return r;
      end
    end
    // chain exhausted: full on insert, not found on search
    return r;
  endfunction

  function automatic req_t make_req(input logic kind, input logic [KEY_W-1:0] k);
    req_t rq;
    rq.req_type = kind;
    rq.key      = k;
    return rq;
  endfunction

  // driver: one beat at a time from the backlog, with random idle bursts
  always @(posedge clk_i or negedge rst_ni) begin : drive_req
    logic free;
    if (!rst_ni) begin
      start    <= 1'b0;
      req_i    <= '0;
      gap_left = 0;
    end else begin
      free = !start || !busy;
      if (start && !busy) begin
        // beat taken at this edge: predict its result now, results come back in order
        rsp_pending.push_back(predict_lookup(req_i));
        n_sent++;
      end
      if (free) begin
        if (gap_left == 0 && req_backlog.size() > TAIL_ITEMS && $urandom_range(0, 7) == 0)
          gap_left = $urandom_range(1, 15);
        if (gap_left > 0) begin
          gap_left--;
          start <= 1'b0;
        end else if (req_backlog.size() != 0) begin
          start <= 1'b1;
          req_i <= req_backlog.pop_front();
        end else begin
          start <= 1'b0;
        end
      end
    end
  end

  // monitor: each result beat against the oldest prediction
  always @(posedge clk_i) begin : watch_rsp
    rsp_t want;
    if (rst_ni && done_o) begin
      if (rsp_pending.size() == 0) begin
        flag_mismatch($sformatf("unexpected result beat status=%0d slot=%0d",
                                rsp_o.status, rsp_o.slot_index));
      end else begin
        want = rsp_pending.pop_front();
        n_checked++;
        n_status[want.status]++;
        if (rsp_o.status !== want.status)
          flag_mismatch($sformatf("beat %0d status got %0d want %s", n_checked,
                                  rsp_o.status, want.status.name()));
        if (rsp_o.slot_index !== want.slot_index)
          flag_mismatch($sformatf("beat %0d slot_index got %0d want %0d", n_checked,
                                  rsp_o.slot_index, want.slot_index));
      end
    end
  end

  // stimulus and end of run
  initial begin : stimulus
    logic [KEY_W-1:0] known_keys [$];
    logic [KEY_W-1:0] k;
    int unsigned      pick;
    int unsigned      drain;

    foreach (slot_mirror[i]) slot_mirror[i] = '0;

    // zero key both ways, empty-table search, extreme keys
    req_backlog.push_back(make_req(REQ_SEARCH, '0));
    req_backlog.push_back(make_req(REQ_INSERT, '0));
    req_backlog.push_back(make_req(REQ_SEARCH, 31'h7FFF_FFFF));
    req_backlog.push_back(make_req(REQ_INSERT, 31'h7FFF_FFFF));
    req_backlog.push_back(make_req(REQ_SEARCH, 31'h7FFF_FFFF));
    req_backlog.push_back(make_req(REQ_INSERT, 31'd1));
    req_backlog.push_back(make_req(REQ_SEARCH, 31'd1));
    // one home slot chain: duplicate first, then keys until the chain is exhausted
    req_backlog.push_back(make_req(REQ_INSERT, 31'd3));
    req_backlog.push_back(make_req(REQ_INSERT, 31'd3));
    for (int j = 0; j < 6; j++)
      req_backlog.push_back(make_req(REQ_INSERT, KEY_W'(3 + 11 * (j + 1))));
    req_backlog.push_back(make_req(REQ_SEARCH, 31'd3));
    req_backlog.push_back(make_req(REQ_SEARCH, 31'd47));
    req_backlog.push_back(make_req(REQ_SEARCH, 31'd58));
    // same home, never stored: chain has no empty slot left
    req_backlog.push_back(make_req(REQ_SEARCH, 31'd80));
    req_backlog.push_back(make_req(REQ_INSERT, 31'h4000_0000));
    req_backlog.push_back(make_req(REQ_SEARCH, 31'h4000_0000));
    req_backlog.push_back(make_req(REQ_SEARCH, 31'h2AAA_AAAA));
    req_backlog.push_back(make_req(REQ_SEARCH, 31'h5555_5555));
    known_keys = '{31'd1, 31'd3, 31'd47, 31'h7FFF_FFFF, 31'h4000_0000};

    // random part: inserts paired with searches, lookups of stored keys, and noise
    for (int unsigned n = 0; n < RAND_ITEMS; n++) begin
      pick = $urandom_range(0, 99);
      case ($urandom_range(0, 3))
        0:       k = KEY_W'($urandom());
        1:       k = KEY_W'($urandom_range(1, 200));
        default: k = known_keys[$urandom_range(0, known_keys.size() - 1)];
      endcase
      if ($urandom_range(0, 49) == 0) k = '0;
      if (pick < 20) begin
        // insert then look the same key up straight away
        req_backlog.push_back(make_req(REQ_INSERT, k));
        req_backlog.push_back(make_req(REQ_SEARCH, k));
        known_keys.push_back(k);
        n++;
      end else if (pick < 35) begin
        req_backlog.push_back(make_req(REQ_INSERT, k));
        known_keys.push_back(k);
      end else begin
        req_backlog.push_back(make_req(REQ_SEARCH, k));
      end
    end

    wait (rst_ni);
    while (req_backlog.size() != 0 || start) @(posedge clk_i);
    drain = 0;
    while (rsp_pending.size() != 0 && drain < DRAIN_LIMIT) begin
      @(posedge clk_i);
      drain++;
    end
    // catch any stray result beat after the last one expected
    repeat (SETTLE) @(posedge clk_i);
    if (rsp_pending.size() != 0)
      flag_mismatch($sformatf("%0d results never arrived", rsp_pending.size()));

    $display("sent %0d requests, checked %0d results", n_sent, n_checked);
    $display("inserted %0d, no free slot %0d, found %0d, not found %0d, mismatches %0d",
             n_status[ST_INSERTED], n_status[ST_FULL], n_status[ST_FOUND],
             n_status[ST_MISSING], err_count);
    if (err_count == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule

// ----- files.f -----
design/htqp_pkg.sv
design/htqp_fifo.sv
design/htqp_front.sv
design/htqp_back.sv
design/hash_table_quadratic_probe.sv
dv/hash_table_quadratic_probe_tb.sv
